@@ hdl/ckb_pkg.sv @@
package ckb_pkg;

    // Field widths of the stream items
    localparam int PIXEL_W     = 32;
    localparam int DEST_X_W    = 10;
    localparam int DEST_Y_W    = 9;
    localparam int OUT_TDATA_W = 56;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_X        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_Y         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_MODE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TINT_COLOR    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_PERCENT  = 3'd6;

    // Draw modes; any other code draws keyed transparent
    localparam logic [1:0] MODE_KEY_FILL = 2'd1;
    localparam logic [1:0] MODE_KEY_TINT = 2'd2;

    localparam logic [PIXEL_W-1:0] KEY_MASK = 32'h00FF_FFFF;

    // Percentage scaling: x / 100 == (x * FILL_RECIP) >> FILL_SHIFT for x < 199728
    localparam logic [6:0]  FILL_MAX    = 7'd100;
    localparam int          FILL_SHIFT  = 24;
    localparam int          FILL_SCL_W  = 25;
    localparam logic [17:0] FILL_RECIP  = 18'd167773;

    // Signed width of the clip window arithmetic, enough for screens up to 4096
    localparam int WIN_W = 14;

    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    typedef struct packed {
        logic        [9:0]       sprite_width;
        logic signed [10:0]      left_x;
        logic signed [10:0]      top_y;
        logic        [1:0]       draw_mode;
        logic        [31:0]      tint_color;
        logic        [10:0]      col_skip;
        logic        [10:0]      row_skip;
        logic signed [WIN_W-1:0] draw_w;
        logic signed [WIN_W-1:0] draw_h;
    } t_cfg;

endpackage

@@ hdl/color_key_sprite_blitter.sv @@
// Colour-key sprite blitter. Sprite pixels enter on the slave stream in raster order,
// top row first, one transaction per pixel, with tuser set on the first pixel of a
// sprite to restart the row and column counters. Each pixel is placed at the
// configured top-left position (software subtracts the sprite centre beforehand),
// clipped against the screen edges and against the drawn width of sprite_width times
// fill_percent over 100, and then either dropped, written as it is, filled white or
// ORed with the tint, depending on the draw mode and the white colour key. Every pixel
// that survives gives one framebuffer write transaction on the master stream. The block
// takes one pixel per clock cycle while back-pressure does not stall it, and a pixel's
// write path to the master stream is three registers deep: the input register, the
// offset stage and the output register fed by the window compare.
// Back-pressure on the master side stalls the pipeline only once its bubbles are used
// up. The clip window is derived from the registers through a registered width
// multiplier followed by the registered window terms.
module color_key_sprite_blitter
    import ckb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Sprite pixel stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,   // [31:0] sprite_pixel
    input  logic [0:0]             s_tuser,   // [0] first_pixel
    // Framebuffer write stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [9:0] dest_x, [18:10] dest_y,
                                              // [50:19] out_pixel, [55:51] zero
);

    t_cfg cfg;

    ckb_cfg #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Pipeline flow control. Each stage loads when it is empty or its successor loads,
    // so bubbles are squeezed out before back-pressure reaches the input.
    logic r_v1, r_v2;
    logic adv1, adv2, adv3, s_accept;

    always_comb begin
        adv3     = !m_tvalid || m_tready;
        adv2     = !r_v2 || adv3;
        adv1     = !r_v1 || adv2;
        s_accept = s_tvalid && adv1;
    end

    assign s_tready = adv1;

    // Sprite position counters. The first pixel of a sprite uses row and column zero.
    logic [9:0] r_col_count, r_row_count;
    logic [9:0] col_base, row_base, col_inc, n_col_count, n_row_count;

    always_comb begin
        col_base = s_tuser[0] ? '0 : r_col_count;
        row_base = s_tuser[0] ? '0 : r_row_count;
        col_inc  = col_base + 10'd1;
        if (col_inc >= cfg.sprite_width) begin
            n_col_count = '0;
            n_row_count = row_base + 10'd1;
        end else begin
            n_col_count = col_inc;
            n_row_count = row_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (s_accept) begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
        end
    end

    // Stage 1: the pixel with the sprite position it was taken at.
    logic [PIXEL_W-1:0] r1_pix;
    logic [9:0]         r1_col, r1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r1_pix <= s_tdata;
            r1_col <= col_base;
            r1_row <= row_base;
        end
    end

    // Stage 2: offsets into the clip window, destination and the colour-key decision.
    // The destination is the sprite position plus the signed top-left corner, whether
    // or not the corner is clipped, so it needs no window terms.
    logic                 is_key, do_write;
    logic [PIXEL_W-1:0]   pix_val;
    logic signed [11:0]   n2_r, n2_c;

    always_comb begin
        is_key   = (r1_pix & KEY_MASK) == KEY_MASK;
        do_write = !is_key;
        pix_val  = r1_pix;
        case (cfg.draw_mode)
            MODE_KEY_FILL: begin
                do_write = 1'b1;
                if (is_key) begin
                    pix_val = KEY_MASK;
                end
            end
            MODE_KEY_TINT: pix_val = r1_pix | cfg.tint_color;
            default: ;
        endcase
        n2_r = $signed({2'b00, r1_row}) - $signed({1'b0, cfg.row_skip});
        n2_c = $signed({2'b00, r1_col}) - $signed({1'b0, cfg.col_skip});
    end

    logic signed [11:0]  r2_r, r2_c;
    logic [DEST_X_W-1:0] r2_dx;
    logic [DEST_Y_W-1:0] r2_dy;
    logic [PIXEL_W-1:0]  r2_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1 && do_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_r   <= n2_r;
            r2_c   <= n2_c;
            r2_dx  <= r1_col + cfg.left_x[DEST_X_W-1:0];
            r2_dy  <= r1_row[DEST_Y_W-1:0] + cfg.top_y[DEST_Y_W-1:0];
            r2_pix <= pix_val;
        end
    end

    // Stage 3: window test into the output register. A negative window never passes,
    // since the offset must be at least zero and below the window size.
    logic visible;

    always_comb begin
        visible = !r2_r[11] && !r2_c[11]
               && ($signed({{(WIN_W-12){r2_r[11]}}, r2_r}) < cfg.draw_h)
               && ($signed({{(WIN_W-12){r2_c[11]}}, r2_c}) < cfg.draw_w);
    end

    logic                r_v3;
    logic [DEST_X_W-1:0] r3_dx;
    logic [DEST_Y_W-1:0] r3_dy;
    logic [PIXEL_W-1:0]  r3_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2 && visible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_pix <= r2_pix;
        end
    end

    assign m_tvalid = r_v3;
    assign m_tdata  = {5'd0, r3_pix, r3_dy, r3_dx};

    // With the output register free, the whole pipeline can move, so input is taken.
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    // A write only appears after a writing pixel reached the window test.
    a_out_from_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_v2))
        else $error("framebuffer write without a pixel in the window stage");

    // Clipping keeps every write left of the right screen edge.
    a_dest_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (SCREEN_WIDTH > 1024 || int'(r3_dx) < SCREEN_WIDTH))
        else $error("framebuffer write beyond the right screen edge");

endmodule

@@ hdl/ckb_cfg.sv @@
module ckb_cfg
    import ckb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    localparam logic signed [WIN_W-1:0] SW_W = WIN_W'(SCREEN_WIDTH);
    localparam logic signed [WIN_W-1:0] SH_W = WIN_W'(SCREEN_HEIGHT);

    logic        [9:0]            r_sprite_width;
    logic        [9:0]            r_sprite_height;
    logic signed [10:0]           r_left_x;
    logic signed [10:0]           r_top_y;
    logic        [1:0]            r_draw_mode;
    logic        [31:0]           r_tint_color;
    logic        [FILL_SCL_W-1:0] r_fill_scaled;
    logic        [9:0]            r_draw_w_raw;
    logic        [10:0]           r_col_skip;
    logic        [10:0]           r_row_skip;
    logic signed [WIN_W-1:0]      r_draw_w;
    logic signed [WIN_W-1:0]      r_draw_h;

    logic        [6:0]            fill_clamped;
    logic        [FILL_SCL_W-1:0] n_fill_scaled;
    logic        [34:0]           width_product;
    logic signed [WIN_W-1:0]      lx_w, ty_w, x_pos, y_pos, x_end, y_end, x_over, y_over;
    logic signed [WIN_W-1:0]      n_draw_w, n_draw_h, n_col_skip, n_row_skip;

    always_comb begin
        fill_clamped  = (i_cfg_data[6:0] > FILL_MAX) ? FILL_MAX : i_cfg_data[6:0];
        n_fill_scaled = FILL_SCL_W'(fill_clamped) * FILL_SCL_W'(FILL_RECIP);
        width_product = {25'd0, r_sprite_width} * {10'd0, r_fill_scaled};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_width  <= '0;
            r_sprite_height <= '0;
            r_left_x        <= '0;
            r_top_y         <= '0;
            r_draw_mode     <= '0;
            r_tint_color    <= '0;
            r_fill_scaled   <= FILL_SCL_W'(FILL_MAX) * FILL_SCL_W'(FILL_RECIP);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[9:0];
                CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[9:0];
                CFG_LEFT_X:        r_left_x        <= i_cfg_data[10:0];
                CFG_TOP_Y:         r_top_y         <= i_cfg_data[10:0];
                CFG_DRAW_MODE:     r_draw_mode     <= i_cfg_data[1:0];
                CFG_TINT_COLOR:    r_tint_color    <= i_cfg_data[31:0];
                CFG_FILL_PERCENT:  r_fill_scaled   <= n_fill_scaled;
                default: ;
            endcase
        end
    end

    // Clip the window against the screen edges. The right and bottom tests use the
    // full sprite size rather than the drawn width, as the original blitter does.
    always_comb begin
        lx_w  = {{(WIN_W-11){r_left_x[10]}}, r_left_x};
        ty_w  = {{(WIN_W-11){r_top_y[10]}}, r_top_y};
        x_pos = lx_w[WIN_W-1] ? '0 : lx_w;
        y_pos = ty_w[WIN_W-1] ? '0 : ty_w;
        x_end = x_pos + $signed({{(WIN_W-10){1'b0}}, r_sprite_width});
        y_end = y_pos + $signed({{(WIN_W-10){1'b0}}, r_sprite_height});
        x_over = (x_end >= SW_W) ? x_end - SW_W : '0;
        y_over = (y_end >= SH_W) ? y_end - SH_W : '0;
        n_draw_w = $signed({{(WIN_W-10){1'b0}}, r_draw_w_raw})
                 + (lx_w[WIN_W-1] ? lx_w : '0) - x_over;
        n_draw_h = $signed({{(WIN_W-10){1'b0}}, r_sprite_height})
                 + (ty_w[WIN_W-1] ? ty_w : '0) - y_over;
        n_col_skip = lx_w[WIN_W-1] ? -lx_w : '0;
        n_row_skip = ty_w[WIN_W-1] ? -ty_w : '0;
    end

    always_ff @(posedge i_clk) begin
        r_draw_w_raw <= width_product[FILL_SHIFT+9:FILL_SHIFT];
        r_draw_w     <= n_draw_w;
        r_draw_h     <= n_draw_h;
        r_col_skip   <= n_col_skip[10:0];
        r_row_skip   <= n_row_skip[10:0];
    end

    always_comb begin
        o_cfg.sprite_width = r_sprite_width;
        o_cfg.left_x       = r_left_x;
        o_cfg.top_y        = r_top_y;
        o_cfg.draw_mode    = r_draw_mode;
        o_cfg.tint_color   = r_tint_color;
        o_cfg.col_skip     = r_col_skip;
        o_cfg.row_skip     = r_row_skip;
        o_cfg.draw_w       = r_draw_w;
        o_cfg.draw_h       = r_draw_h;
    end

endmodule

@@ tb/sv/tb_color_key_sprite_blitter.sv @@
module tb_color_key_sprite_blitter
    import ckb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Draw modes that the package leaves unnamed.
    localparam logic [1:0] MODE_KEY_SKIP = 2'd0;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam int SCREEN_W     = SCREEN_WIDTH_DEF;
    localparam int SCREEN_H     = SCREEN_HEIGHT_DEF;
    localparam int PERCENT      = 100;
    // The pipeline is three stages deep, so the quiet wait after the last write leaves it
    // empty even when the last pixels in flight produce no write.
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 200;
    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_ITEMS  = 120;
    localparam int PRESSURE_PHASE = 2;
    localparam int TIMEOUT_NS   = 3_000_000;

    localparam int DY_LO = DEST_X_W;
    localparam int PX_LO = DEST_X_W + DEST_Y_W;

    // One framebuffer write, as it travels on the master stream.
    typedef struct packed {
        logic [DEST_X_W-1:0] dest_x;
        logic [DEST_Y_W-1:0] dest_y;
        logic [PIXEL_W-1:0]  out_pixel;
    } t_fb_write;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;
    // How a directed pixel is checked: against the predictor, as a pixel known to
    // be dropped, or against the write typed into the row.
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_WRITE} t_row_check;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [31:0]            data;       // register value or sprite pixel
        bit                     first;
        t_row_check             check;
        logic [DEST_X_W-1:0]    x;
        logic [DEST_Y_W-1:0]    y;
        logic [PIXEL_W-1:0]     pixel;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata;    // [31:0] sprite_pixel
    logic [0:0]             s_tuser;    // [0] first_pixel
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [9:0] dest_x, [18:10] dest_y,
                                        // [50:19] out_pixel, [55:51] zero

    // Predictor copy of the register file and of the raster counters.
    logic [9:0]        reg_width;
    logic [9:0]        reg_height;
    logic signed [10:0] reg_left_x;
    logic signed [10:0] reg_top_y;
    logic [1:0]        reg_mode;
    logic [31:0]       reg_tint;
    logic [6:0]        reg_fill;
    logic [9:0]        col_count;
    logic [9:0]        row_count;

    t_fb_write fb_writes[$];        // framebuffer writes still to come out
    int        errors = 0;
    int        items_sent = 0;
    bit        sender_steady = 1'b0;
    bit        receiver_steady = 1'b0;
    bit        hold_output = 1'b0;

    // The directed part. Rows that merely reconfigure are applied while the
    // block is idle; pixel rows carry a typed write only where the answer is
    // obvious from the clip rules, otherwise the predictor decides.
    t_stim_row directed_table [45] = '{
        // After reset the sprite is zero wide, so the window is empty.
        '{ROW_PIX, '0, 32'hFFFF_FFFF, 1'b1, EXP_NONE, '0, '0, '0},
        '{ROW_PIX, '0, 32'h0000_0000, 1'b0, EXP_NONE, '0, '0, '0},
        // A 4 by 2 sprite at the origin, keyed transparent.
        '{ROW_CFG, CFG_SPRITE_WIDTH, 32'd4, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_SPRITE_HEIGHT, 32'd2, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h0000_0000, 1'b1, EXP_WRITE, 10'd0, 9'd0, 32'h0000_0000},
        '{ROW_PIX, '0, 32'hFFFF_FFFF, 1'b0, EXP_NONE, '0, '0, '0},
        '{ROW_PIX, '0, 32'hFF00_0000, 1'b0, EXP_WRITE, 10'd2, 9'd0, 32'hFF00_0000},
        '{ROW_PIX, '0, 32'h00FF_FFFF, 1'b0, EXP_NONE, '0, '0, '0},
        '{ROW_PIX, '0, 32'h1234_5678, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'hFFFF_FFFE, 1'b0, EXP_MODEL, '0, '0, '0},
        // Key pixels are filled white.
        '{ROW_CFG, CFG_DRAW_MODE, 32'(MODE_KEY_FILL), 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'hFFFF_FFFF, 1'b1, EXP_WRITE, 10'd0, 9'd0, KEY_MASK},
        '{ROW_PIX, '0, 32'hABFF_FFFF, 1'b0, EXP_MODEL, '0, '0, '0},
        // Tinted, key still skipped.
        '{ROW_CFG, CFG_DRAW_MODE, 32'(MODE_KEY_TINT), 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_TINT_COLOR, 32'hA500_0000, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h0000_000F, 1'b1, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h80FF_FFFF, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h7F00_FF00, 1'b0, EXP_MODEL, '0, '0, '0},
        // The unused mode code, with a fill percentage above a hundred.
        '{ROW_CFG, CFG_DRAW_MODE, 32'(MODE_UNUSED), 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_FILL_PERCENT, 32'd127, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h00FF_FFFF, 1'b1, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h55AA_55AA, 1'b0, EXP_MODEL, '0, '0, '0},
        // Half the width drawn: the third column falls outside.
        '{ROW_CFG, CFG_FILL_PERCENT, 32'd50, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h0000_0001, 1'b1, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h0000_0002, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h0000_0003, 1'b0, EXP_MODEL, '0, '0, '0},
        // Nothing drawn at all.
        '{ROW_CFG, CFG_FILL_PERCENT, 32'd0, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'hC0C0_C0C0, 1'b1, EXP_NONE, '0, '0, '0},
        // Positions at both extremes leave an empty window.
        '{ROW_CFG, CFG_FILL_PERCENT, 32'd100, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_DRAW_MODE, 32'(MODE_KEY_SKIP), 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_LEFT_X, 32'hFFFF_FC00, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_TOP_Y, 32'hFFFF_FC00, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h0101_0101, 1'b1, EXP_NONE, '0, '0, '0},
        '{ROW_CFG, CFG_LEFT_X, 32'h0000_03FF, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_TOP_Y, 32'h0000_03FF, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h0202_0202, 1'b1, EXP_NONE, '0, '0, '0},
        // One row in the bottom right corner, then a pixel past the last row.
        '{ROW_CFG, CFG_LEFT_X, 32'd636, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_TOP_Y, 32'd479, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_SPRITE_HEIGHT, 32'd1, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_CFG, CFG_DRAW_MODE, 32'(MODE_KEY_FILL), 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'hFFFF_FFFF, 1'b1, EXP_WRITE, 10'd636, 9'd479, KEY_MASK},
        '{ROW_PIX, '0, 32'h1111_1111, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'h2222_2222, 1'b0, EXP_MODEL, '0, '0, '0},
        '{ROW_PIX, '0, 32'hFFFF_FFFF, 1'b0, EXP_WRITE, 10'd639, 9'd479, KEY_MASK},
        '{ROW_PIX, '0, 32'h3333_3333, 1'b0, EXP_NONE, '0, '0, '0}
    };

    color_key_sprite_blitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the framebuffer write that one sprite pixel causes, if any, and
    // advances the raster counters. The clip window is rebuilt for every pixel
    // from the current registers, with the right and bottom edges tested
    // against the full sprite size just as the hardware does.
    function automatic bit blit_pixel(input logic [31:0] pix, input bit first,
                                      output t_fb_write wr);
        int   w, h, fill, dw, dh, x, y, row_skip, col_skip, r, c;
        bit   key, draws;
        logic [31:0] value;
        w = int'(reg_width);
        h = int'(reg_height);
        fill = (reg_fill > FILL_MAX) ? int'(FILL_MAX) : int'(reg_fill);
        if (first) begin
            col_count = '0;
            row_count = '0;
        end
        dw = (w * fill) / PERCENT;
        dh = h;
        x = int'(reg_left_x);
        y = int'(reg_top_y);
        row_skip = 0;
        col_skip = 0;
        if (y < 0) begin
            dh += y;
            row_skip = -y;
            y = 0;
        end
        if (y + h >= SCREEN_H) dh -= y + h - SCREEN_H;
        if (x < 0) begin
            dw += x;
            col_skip = -x;
            x = 0;
        end
        if (x + w >= SCREEN_W) dw -= x + w - SCREEN_W;

        r = int'(row_count) - row_skip;
        c = int'(col_count) - col_skip;
        key = (pix & KEY_MASK) == KEY_MASK;
        draws = 1'b0;
        value = pix;
        if (dw > 0 && dh > 0 && r >= 0 && r < dh && c >= 0 && c < dw) begin
            case (reg_mode)
                MODE_KEY_FILL: begin
                    draws = 1'b1;
                    if (key) value = KEY_MASK;
                end
                MODE_KEY_TINT: begin
                    draws = !key;
                    value = pix | reg_tint;
                end
                default: draws = !key;
            endcase
        end
        wr.dest_x = DEST_X_W'(c + x);
        wr.dest_y = DEST_Y_W'(r + y);
        wr.out_pixel = value;

        col_count = col_count + 10'd1;
        if (col_count >= reg_width) begin
            col_count = '0;
            row_count = row_count + 10'd1;
        end
        return draws;
    endfunction

    // A quarter of the random pixels are colour keys with a random top byte.
    function automatic logic [31:0] random_pixel();
        if ($urandom_range(0, 3) == 0) return {8'($urandom), KEY_MASK[23:0]};
        return $urandom;
    endfunction

    // Mostly small sprites, now and then empty, mid-sized or the largest.
    function automatic int pick_size(input int common_max);
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 1023;
            2, 3:    return $urandom_range(13, 64);
            default: return $urandom_range(1, common_max);
        endcase
    endfunction

    // Positions cluster on the screen edges so that every clip branch is taken.
    function automatic int pick_pos(input int span, input int size);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, span - 1);
            4, 5:       return -int'($urandom_range(0, size + 2));
            6, 7:       return span - size + int'($urandom_range(0, 6)) - 3;
            8:          return int'($urandom_range(0, 2047)) - 1024;
            default:    return ($urandom_range(0, 1) != 0) ? -1024 : 1023;
        endcase
    endfunction

    // Drives one register write and mirrors it into the predictor at the same
    // clock edge at which the block takes it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_SPRITE_WIDTH:  reg_width  = value[9:0];
            CFG_SPRITE_HEIGHT: reg_height = value[9:0];
            CFG_LEFT_X:        reg_left_x = value[10:0];
            CFG_TOP_Y:         reg_top_y  = value[10:0];
            CFG_DRAW_MODE:     reg_mode   = value[1:0];
            CFG_TINT_COLOR:    reg_tint   = value;
            CFG_FILL_PERCENT:  reg_fill   = value[6:0];
            default: ;
        endcase
    endtask

    task automatic close_cfg_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stops offering pixels and waits until every predicted write has come
    // out, then lets the pipeline flush any pixels that produce nothing.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (fb_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offers one pixel, possibly after an idle burst, and records what it
    // should produce once the transaction completes. The valid line is only
    // lowered at the start of a gap, so it is never lowered and raised at the
    // same edge.
    task automatic send_pixel(input logic [31:0] pixel, input bit first,
                              input t_row_check check, input t_fb_write typed);
        t_fb_write predicted;
        bit        writes;
        int        gap;
        gap = (!sender_steady && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        s_tuser  <= first;
        do @(posedge i_clk); while (!s_tready);
        writes = blit_pixel(pixel, first, predicted);
        case (check)
            EXP_MODEL: if (writes) fb_writes.push_back(predicted);
            EXP_WRITE: fb_writes.push_back(typed);
            default: ;
        endcase
        items_sent++;
    endtask

    // One sprite's worth of pixels; a noisy run scatters the first-pixel flag.
    task automatic send_sprite(input int count, input bit noisy);
        bit first;
        for (int i = 0; i < count; i++) begin
            first = noisy ? ($urandom_range(0, 3) == 0) : (i == 0);
            send_pixel(random_pixel(), first, EXP_MODEL, '0);
        end
    endtask

    // Writes every register with a fresh random setting and reports the sprite
    // size chosen, so that the caller can shape the sprites to it.
    task automatic configure_random(output int w, output int h);
        w = pick_size(12);
        h = pick_size(10);
        write_reg(CFG_SPRITE_WIDTH, 32'(w));
        write_reg(CFG_SPRITE_HEIGHT, 32'(h));
        write_reg(CFG_LEFT_X, 32'(pick_pos(SCREEN_W, w)));
        write_reg(CFG_TOP_Y, 32'(pick_pos(SCREEN_H, h)));
        write_reg(CFG_DRAW_MODE, 32'($urandom_range(0, 3)));
        write_reg(CFG_TINT_COLOR, $urandom);
        write_reg(CFG_FILL_PERCENT,
                  ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 127)) : 32'(FILL_MAX));
    endtask

    // Framebuffer write side: random back-pressure in bursts, one long hold on
    // request, and none at all once the run is in its final stretch.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                hold_output = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!receiver_steady && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Every completed write transaction is matched against the oldest
    // prediction, field by field.
    initial begin
        t_fb_write want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                if (fb_writes.size() == 0) begin
                    $error("unexpected framebuffer write: dest_x %0d dest_y %0d out_pixel %h",
                           m_tdata[DY_LO-1:0], m_tdata[PX_LO-1:DY_LO],
                           m_tdata[PX_LO+PIXEL_W-1:PX_LO]);
                    errors++;
                end else begin
                    want = fb_writes.pop_front();
                    if (m_tdata[DY_LO-1:0] !== want.dest_x) begin
                        $error("dest_x: expected %0d, got %0d", want.dest_x, m_tdata[DY_LO-1:0]);
                        errors++;
                    end
                    if (m_tdata[PX_LO-1:DY_LO] !== want.dest_y) begin
                        $error("dest_y: expected %0d, got %0d", want.dest_y,
                               m_tdata[PX_LO-1:DY_LO]);
                        errors++;
                    end
                    if (m_tdata[PX_LO+PIXEL_W-1:PX_LO] !== want.out_pixel) begin
                        $error("out_pixel: expected %h, got %h", want.out_pixel,
                               m_tdata[PX_LO+PIXEL_W-1:PX_LO]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        t_stim_row row;
        bit        in_cfg;
        bit        noisy;
        int        base, phase, sprites, count, w, h;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        reg_width   = '0;
        reg_height  = '0;
        reg_left_x  = '0;
        reg_top_y   = '0;
        reg_mode    = MODE_KEY_SKIP;
        reg_tint    = '0;
        reg_fill    = FILL_MAX;
        col_count   = '0;
        row_count   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: register rows are grouped and applied with the
        // block idle, pixel rows go straight onto the stream.
        in_cfg = 1'b0;
        foreach (directed_table[i]) begin
            row = directed_table[i];
            if (row.kind == ROW_CFG) begin
                if (!in_cfg) drain();
                in_cfg = 1'b1;
                write_reg(row.reg_index, row.data);
            end else begin
                if (in_cfg) close_cfg_writes();
                in_cfg = 1'b0;
                send_pixel(row.data, row.first, row.check, '{row.x, row.y, row.pixel});
            end
        end

        // Random part: each phase draws a new setting and sends a few sprites
        // through it, mostly well formed, some cut short or overrun, and now
        // and then a run with the first-pixel flag scattered at random. One
        // early phase holds the write side off for a long stretch on a fully
        // visible sprite, so that the pipeline fills and stalls its input.
        base = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            drain();
            if (phase == PRESSURE_PHASE) begin
                write_reg(CFG_SPRITE_WIDTH, 32'd8);
                write_reg(CFG_SPRITE_HEIGHT, 32'd8);
                write_reg(CFG_LEFT_X, 32'd100);
                write_reg(CFG_TOP_Y, 32'd100);
                write_reg(CFG_DRAW_MODE, 32'(MODE_KEY_FILL));
                write_reg(CFG_FILL_PERCENT, 32'(FILL_MAX));
                close_cfg_writes();
                hold_output = 1'b1;
                sender_steady = 1'b1;
                send_sprite(64, 1'b0);
                sender_steady = 1'b0;
            end else begin
                configure_random(w, h);
                close_cfg_writes();
                noisy = ($urandom_range(0, 9) == 0);
                sprites = $urandom_range(1, 3);
                for (int s = 0; s < sprites; s++) begin
                    count = w * h;
                    if (count == 0) count = $urandom_range(1, 12);
                    else if (count > 48) count = $urandom_range(16, 48);
                    case ($urandom_range(0, 7))
                        0: count += $urandom_range(1, 8);
                        1: count = $urandom_range(1, count);
                        default: ;
                    endcase
                    send_sprite(count, noisy);
                end
            end
            // The final stretch runs with neither side idling.
            if (items_sent - base >= RANDOM_ITEMS - QUIET_ITEMS) begin
                sender_steady = 1'b1;
                receiver_steady = 1'b1;
            end
            phase++;
        end

        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
